>>> src/crc_bit_serial_encode_check_assert.svh
// ----------------------------------------------------------------------------
// crc assertion macros
// shared concurrent assertion forms for the crc encode/check block
// ----------------------------------------------------------------------------
`ifndef CRC_BIT_SERIAL_ENCODE_CHECK_ASSERT_SVH
`define CRC_BIT_SERIAL_ENCODE_CHECK_ASSERT_SVH

// condition must never hold outside reset
`define CRC_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) else $error(msg);

// same-cycle implication
`define CRC_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CRC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/crcbs_pkg.sv
// ----------------------------------------------------------------------------
// crcbs_pkg
// shared types and constants of the bit-serial crc encoder/checker
// ----------------------------------------------------------------------------
package crcbs_pkg;

	localparam int MAX_DEGREE = 32;
	localparam int REG_W      = 32;
	localparam int DEG_W      = 6;
	localparam int IDX_W      = 2;
	localparam int CNT_W      = $clog2(MAX_DEGREE + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_GENERATOR_POLY = 2'd0,
		REG_POLY_DEGREE    = 2'd1,
		REG_CHECK_MODE     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [MAX_DEGREE-1:0] generator_poly;
		logic [DEG_W-1:0]      poly_degree;
		logic                  check_mode;
	} cfg_t;

	// one classified transaction handed from front to back
	typedef struct packed {
		logic                  data_bit;
		logic                  out_last;
		logic                  crc_error;
		logic                  append;
		logic [MAX_DEGREE-1:0] rem_al;
		logic [CNT_W-1:0]      degree;
	} job_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] cnt;
	} bk_status_t;

endpackage

>>> src/crcbs_front.sv
// ----------------------------------------------------------------------------
// crcbs_front
// accepts bits, steps the remainder and classifies each transaction
// ----------------------------------------------------------------------------
module crcbs_front
	import crcbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic push,
	input  logic data_bit,
	input  logic frame_end,
	input  logic q_full,
	output logic enq,
	output job_t job
);

	logic [MAX_DEGREE-1:0] remainder_q;
	logic [DEG_W-1:0]      deg_eff;
	logic [DEG_W-1:0]      deg_m1;
	logic [DEG_W-1:0]      sh_amt;
	logic [MAX_DEGREE:0]   mask_w;
	logic [MAX_DEGREE-1:0] mask;
	logic [MAX_DEGREE-1:0] poly;
	logic [MAX_DEGREE-1:0] rem_m;
	logic [MAX_DEGREE-1:0] rem_next;
	logic                  top;

	always_comb begin
		if (cfg.poly_degree == '0) begin
			deg_eff = DEG_W'(1);
		end else if (cfg.poly_degree > DEG_W'(MAX_DEGREE)) begin
			deg_eff = DEG_W'(MAX_DEGREE);
		end else begin
			deg_eff = cfg.poly_degree;
		end
		deg_m1 = deg_eff - DEG_W'(1);
		sh_amt = DEG_W'(MAX_DEGREE) - deg_eff;
		mask_w = ((MAX_DEGREE+1)'(1) << deg_eff) - (MAX_DEGREE+1)'(1);
		mask   = mask_w[MAX_DEGREE-1:0];
		poly   = cfg.generator_poly & mask;
		rem_m  = remainder_q & mask;
		top    = rem_m[deg_m1[$clog2(MAX_DEGREE)-1:0]];
		if (!cfg.check_mode) begin
			rem_next = ((rem_m << 1) & mask) ^ ((top ^ data_bit) ? poly : '0);
		end else begin
			rem_next = (((rem_m << 1) | MAX_DEGREE'(data_bit)) & mask) ^ (top ? poly : '0);
		end
	end

	assign enq = push && !q_full;

	always_comb begin
		job.data_bit  = data_bit;
		job.out_last  = cfg.check_mode && frame_end;
		job.crc_error = cfg.check_mode && frame_end && (rem_next != '0);
		job.append    = !cfg.check_mode && frame_end;
		job.rem_al    = rem_next << sh_amt[$clog2(MAX_DEGREE)-1:0];
		job.degree    = CNT_W'(deg_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
		end else if (enq) begin
			remainder_q <= frame_end ? '0 : rem_next;
		end
	end

endmodule

>>> src/crcbs_fifo.sv
// ----------------------------------------------------------------------------
// crcbs_fifo
// two-entry queue of classified transactions between front and back
// ----------------------------------------------------------------------------
module crcbs_fifo
	import crcbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	input  logic rd,
	output job_t rd_job,
	output logic q_full,
	output logic q_empty
);

	job_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign rd_job  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/crcbs_back.sv
// ----------------------------------------------------------------------------
// crcbs_back
// expands transactions into results and holds the output register
// ----------------------------------------------------------------------------
module crcbs_back
	import crcbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_job,
	output logic       deq,
	input  logic       pop,
	output logic       empty,
	output logic       out_bit,
	output logic       out_last,
	output logic       crc_error,
	output bk_status_t status
);

	logic                  ovalid_q;
	logic                  obit_q;
	logic                  olast_q;
	logic                  oerr_q;
	logic [MAX_DEGREE-1:0] shift_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  load;

	assign load = !ovalid_q || pop;
	assign deq  = load && (cnt_q == '0) && !q_empty;

	assign empty     = !ovalid_q;
	assign out_bit   = obit_q;
	assign out_last  = olast_q;
	assign crc_error = oerr_q;

	assign status.busy = (cnt_q != '0);
	assign status.cnt  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else if (load) begin
			if (cnt_q != '0) begin
				ovalid_q <= 1'b1;
				cnt_q    <= cnt_q - CNT_W'(1);
			end else if (!q_empty) begin
				ovalid_q <= 1'b1;
				cnt_q    <= q_job.append ? q_job.degree : '0;
			end else begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (cnt_q != '0) begin
				obit_q  <= shift_q[MAX_DEGREE-1];
				olast_q <= (cnt_q == CNT_W'(1));
				oerr_q  <= 1'b0;
				shift_q <= shift_q << 1;
			end else if (!q_empty) begin
				obit_q  <= q_job.data_bit;
				olast_q <= q_job.out_last;
				oerr_q  <= q_job.crc_error;
				shift_q <= q_job.rem_al;
			end
		end
	end

endmodule

>>> src/crc_bit_serial_encode_check.sv
// ----------------------------------------------------------------------------
// crc_bit_serial_encode_check
// bit-serial crc encoder (appends remainder) and checker (flags error)
// ----------------------------------------------------------------------------
// channel   | handshake        | payload
// input     | push / full      | data_bit, frame_end
// results   | pop / empty      | out_bit, out_last, crc_error
// config    | wr_en            | wr_index, wr_data
//
// one bit is accepted per cycle while full is low; the remainder step is one shift and xor
// an encode frame adds one result per check bit (degree clamped to 1..32) after its last bit
// the back serializer emits one result per cycle if not stalled, a 2-entry queue absorbs it
// full rises when the queue holds two transactions; pop stalls hold the output
// reset clears the remainder, queue and serializer; config resets to 0, 1, 0
// ----------------------------------------------------------------------------
`include "crc_bit_serial_encode_check_assert.svh"

module crc_bit_serial_encode_check
	import crcbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             data_bit,
	input  logic             frame_end,
	output logic             empty,
	input  logic             pop,
	output logic             out_bit,
	output logic             out_last,
	output logic             crc_error,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0] wr_data
);

	cfg_t       cfg_q;
	logic       enq;
	logic       deq;
	logic       q_full;
	logic       q_empty;
	job_t       job_in;
	job_t       job_out;
	bk_status_t bk_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.generator_poly <= '0;
			cfg_q.poly_degree    <= DEG_W'(1);
			cfg_q.check_mode     <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_GENERATOR_POLY: cfg_q.generator_poly <= wr_data[MAX_DEGREE-1:0];
				REG_POLY_DEGREE:    cfg_q.poly_degree    <= wr_data[DEG_W-1:0];
				REG_CHECK_MODE:     cfg_q.check_mode     <= wr_data[0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	assign full = q_full;

	crcbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.data_bit  (data_bit),
		.frame_end (frame_end),
		.q_full    (q_full),
		.enq       (enq),
		.job       (job_in)
	);

	crcbs_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (enq),
		.wr_job  (job_in),
		.rd      (deq),
		.rd_job  (job_out),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	crcbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (job_out),
		.deq       (deq),
		.pop       (pop),
		.empty     (empty),
		.out_bit   (out_bit),
		.out_last  (out_last),
		.crc_error (crc_error),
		.status    (bk_status)
	);

	`CRC_ASSERT_IMPL(a_busy_has_output, clk, arst_n, bk_status.busy, !empty, "remainder pending without a valid result")
	`CRC_ASSERT_NEXT(a_cnt_steps, clk, arst_n, bk_status.busy && pop && !empty, bk_status.cnt == $past(bk_status.cnt) - CNT_W'(1), "remainder count did not step on pop")
	`CRC_ASSERT_NEVER(a_no_deq_while_busy, clk, arst_n, deq && bk_status.busy, "queue drained while remainder still pending")
	`CRC_ASSERT_NEVER(a_err_only_last, clk, arst_n, !empty && crc_error && !out_last, "crc_error on a result that is not last")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bit-serial crc encoder/checker: random frames,
// random generators and degrees (extremes included), codewords with and
// without injected errors, mid-frame reconfiguration, and stalls on both
// sides of the queue interfaces
// ----------------------------------------------------------------------------
module tb;
	import crcbs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic bit_val;
		logic last;
		logic err;
	} crc_result_t;

	class crc_scoreboard;
		logic [31:0]   gen_poly;
		logic [5:0]    deg_reg;
		logic          mode_reg;
		logic [63:0]   rem_acc;
		crc_result_t   crc_out_q[$];
		int            errors;
		int            checked;
		int            frames_done;
		int            flagged;

		function new();
			gen_poly    = '0;
			deg_reg     = 6'd1;
			mode_reg    = 1'b0;
			rem_acc     = '0;
			errors      = 0;
			checked     = 0;
			frames_done = 0;
			flagged     = 0;
		endfunction

		function int pending();
			return crc_out_q.size();
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_GENERATOR_POLY: gen_poly = val;
				REG_POLY_DEGREE:    deg_reg  = val[5:0];
				REG_CHECK_MODE:     mode_reg = val[0];
				default: ;
			endcase
		endfunction

		// one step of the long division, queues the results this bit causes
		function void absorb_bit(logic din, logic fend);
			int unsigned  d;
			logic [63:0]  mask;
			logic [63:0]  p;
			logic [63:0]  r;
			logic         top;
			logic         fb;
			d = deg_reg;
			if (d < 1) d = 1;
			if (d > MAX_DEGREE) d = MAX_DEGREE;
			mask = (64'd1 << d) - 64'd1;
			p    = {32'd0, gen_poly} & mask;
			r    = rem_acc & mask;
			top  = r[d-1];
			if (!mode_reg) begin
				fb = top ^ din;
				r  = (r << 1) & mask;
				if (fb) r = r ^ p;
				crc_out_q.push_back(crc_result_t'{din, 1'b0, 1'b0});
				if (fend) begin
					for (int i = 0; i < d; i++)
						crc_out_q.push_back(crc_result_t'{r[d-1-i], (i == d - 1), 1'b0});
					r = '0;
				end
			end else begin
				r = ((r << 1) | {63'd0, din}) & mask;
				if (top) r = r ^ p;
				crc_out_q.push_back(crc_result_t'{din, fend, fend && (r != 0)});
				if (fend) r = '0;
			end
			rem_acc = r;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic b, logic l, logic e);
			crc_result_t want;
			checked++;
			if (l) frames_done++;
			if (e) flagged++;
			if (crc_out_q.size() == 0) begin
				report($sformatf("unexpected result bit=%0b last=%0b err=%0b", b, l, e));
				return;
			end
			want = crc_out_q.pop_front();
			if (b !== want.bit_val)
				report($sformatf("out_bit %0b, want %0b", b, want.bit_val));
			if (l !== want.last)
				report($sformatf("out_last %0b, want %0b", l, want.last));
			if (e !== want.err)
				report($sformatf("crc_error %0b, want %0b", e, want.err));
		endtask
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             push      = 1'b0;
	logic             full;
	logic             data_bit  = 1'b0;
	logic             frame_end = 1'b0;
	logic             empty;
	logic             pop       = 1'b0;
	logic             out_bit;
	logic             out_last;
	logic             crc_error;
	logic             wr_en     = 1'b0;
	logic [IDX_W-1:0] wr_index  = '0;
	logic [REG_W-1:0] wr_data   = '0;

	crc_scoreboard sb;
	int            send_idle_pct = 32;
	int            recv_idle_pct = 78;
	int            hold_left     = 0;
	int            bits_sent     = 0;
	int            reg_writes    = 0;
	int            cycle_cnt     = 0;
	logic [31:0]   cur_poly      = '0;
	logic [5:0]    cur_deg       = 6'd1;
	logic          cur_mode      = 1'b0;

	crc_bit_serial_encode_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_bit  (data_bit),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop),
		.out_bit   (out_bit),
		.out_last  (out_last),
		.crc_error (crc_error),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) sb.write_reg(reg_idx_t'(wr_index), wr_data);
			if (push && !full) sb.absorb_bit(data_bit, frame_end);
			if (pop && !empty) sb.check_result(out_bit, out_last, crc_error);
		end
	end

	// receiver, with an optional long hold-off
	initial forever begin
		@(negedge clk);
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task send_item(input logic d, input logic fe);
		push      <= 1'b1;
		data_bit  <= d;
		frame_end <= fe;
		@(posedge clk);
		while (full) @(posedge clk);
		bits_sent++;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
	endtask

	task wait_idle();
		push <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task set_config(input logic [31:0] poly, input logic [5:0] deg, input logic mode);
		wait_idle();
		wr_en    <= 1'b1;
		wr_index <= REG_GENERATOR_POLY;
		wr_data  <= poly;
		@(negedge clk);
		wr_index <= REG_POLY_DEGREE;
		wr_data  <= ($urandom & ~32'h3F) | {26'd0, deg};
		@(negedge clk);
		wr_index <= REG_CHECK_MODE;
		wr_data  <= ($urandom & ~32'h1) | {31'd0, mode};
		@(negedge clk);
		wr_en    <= 1'b0;
		cur_poly = poly;
		cur_deg  = deg;
		cur_mode = mode;
		reg_writes += 3;
	endtask

	task pick_config();
		int unsigned sel;
		logic [5:0]  deg;
		logic [31:0] poly;
		sel = $urandom_range(0, 19);
		if (sel == 0) deg = 6'd0;
		else if (sel == 1) deg = 6'd32;
		else if (sel == 2) deg = 6'($urandom_range(33, 63));
		else if (sel < 6) deg = 6'($urandom_range(9, 31));
		else deg = 6'($urandom_range(1, 8));
		sel = $urandom_range(0, 9);
		if (sel == 0) poly = '0;
		else if (sel == 1) poly = '1;
		else poly = $urandom;
		set_config(poly, deg, 1'($urandom_range(0, 1)));
	endtask

	task send_frame(input logic frame[$]);
		int split;
		split = 0;
		if (frame.size() > 1 && $urandom_range(0, 15) == 0)
			split = $urandom_range(1, frame.size() - 1);
		for (int i = 0; i < frame.size(); i++) begin
			if (split != 0 && i == split) pick_config();
			send_item(frame[i], i == frame.size() - 1);
		end
	endtask

	task run_phase(input int send_pct, input int recv_pct, input int n_items, input int hold);
		logic          frame[$];
		crc_scoreboard scratch;
		crc_result_t   res;
		int            len;
		int            flip;
		int            start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = bits_sent;
		pick_config();
		if (hold > 0) hold_left = hold;
		while (bits_sent - start < n_items) begin
			if ($urandom_range(0, 3) == 0) pick_config();
			frame.delete();
			if (cur_mode && $urandom_range(0, 9) < 7) begin
				// codeword built by encoding a random message, sometimes corrupted
				scratch = new();
				scratch.write_reg(REG_GENERATOR_POLY, cur_poly);
				scratch.write_reg(REG_POLY_DEGREE, {26'd0, cur_deg});
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					scratch.absorb_bit(1'($urandom_range(0, 1)), i == len - 1);
				while (scratch.pending() != 0) begin
					res = scratch.crc_out_q.pop_front();
					frame.push_back(res.bit_val);
				end
				if ($urandom_range(0, 9) < 3) begin
					flip = $urandom_range(0, frame.size() - 1);
					frame[flip] = ~frame[flip];
				end
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					frame.push_back(1'($urandom_range(0, 1)));
			end
			send_frame(frame);
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: degree 1, zero generator
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b1);
		// widest degree, encode then check
		set_config(32'h04C1_1DB7, 6'd32, 1'b0);
		send_item(1'b1, 1'b1);
		set_config(32'h04C1_1DB7, 6'd32, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b1);
		// degree zero and degree above the maximum
		set_config(32'hFFFF_FFFF, 6'd0, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		set_config(32'hFFFF_FFFF, 6'd63, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b1);
		// generator bits above the degree, mode switched mid-frame
		set_config(32'hFFFF_FFF3, 6'd3, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		set_config(32'hFFFF_FFF3, 6'd3, 1'b1);
		send_item(1'b1, 1'b1);
		// degree shrunk mid-frame
		set_config(32'h0000_0005, 6'd5, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b0);
		set_config(32'h0000_0005, 6'd2, 1'b0);
		send_item(1'b0, 1'b1);
		// valid codeword of x^3 + x + 1
		set_config(32'h0000_0003, 6'd3, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);

		run_phase(32, 78, 160, 250);
		run_phase(78, 32, 160, 0);
		run_phase(0, 0, 160, 300);

		wait_idle();
		repeat (40) @(negedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));

		$display("covered %0d input bits in %0d frames, %0d results checked, %0d crc errors flagged",
			bits_sent, sb.frames_done, sb.checked, sb.flagged);
		$display("%0d register writes across degrees 0..63, both modes, mid-frame changes",
			reg_writes);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
